// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Request codes and the per-cycle control word shared by the table and its
// cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Request codes carried in the operation field of an item
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_ERASE    = 3'd1;
  localparam logic [2:0] OP_LOOKUP   = 3'd2;
  localparam logic [2:0] OP_PURGE_LE = 3'd3;
  localparam logic [2:0] OP_PURGE_LT = 3'd4;
  localparam logic [2:0] OP_RANK     = 3'd5;

  // Width of the capacity register and of the reported count
  localparam int unsigned CAP_W = 5;

  // Movement command broadcast to every cell in the row
  typedef struct packed {
    logic ins;   // open a slot at the insert point and shift the tail right
    logic del;   // close the slot of the matching entry, shift the tail left
    logic shl;   // shift the whole row left by one (purge step)
  } skt_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_key_table_with_range_purge_core.sv
// ----------------------------------------------------------------------------
// Sorted key table with range purge
// Bounded table of key/payload entries kept in ascending key order in a row
// of cells, with insert, erase, lookup, rank read and range purge requests.
// ----------------------------------------------------------------------------
// For insert, erase, lookup, rank read and unknown requests, every cell
// compares its entry with the request key at once and the row shifts by one
// place in the same cycle, so these items are accepted back to back while the
// result side is not stalled. A purge removes one entry per cycle from the
// front of the row, and no item is accepted meanwhile. The room compare of
// count against capacity is used by inserts only; there is no clearing pass
// after reset, as cells beyond the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_with_range_purge_core #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // capacity register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_capacity,
  // request items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_payload,
  input  wire logic [3:0]  in_rank,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [31:0]      out_payload_out,
  output logic [31:0]      out_key_out,
  output logic [4:0]       out_count,
  output logic             out_full_res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  logic                      state_r;
  logic                      state_nxt;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [skt_pkg::CAP_W-1:0] cap_r;
  logic [KEY_BITS-1:0]       bound_r;
  logic                      purge_le_r;
  logic                      removed_r;
  logic                      removed_nxt;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_ok_r;
  logic [31:0] out_pay_r;
  logic [31:0] out_key_r;
  logic [4:0]  out_count_r;
  logic        out_full_r;

  logic                in_fire;
  logic                out_free;
  logic [63:0]         in_key_ext;
  logic [KEY_BITS-1:0] in_kw;
  logic [KEY_BITS-1:0] cmp_key;
  logic [31:0]         eff_cap;
  logic                room;
  logic                found;
  logic                purge_hit;
  logic                load_out;
  logic                res_ok;
  logic [31:0]         res_pay;
  logic [31:0]         res_key;
  logic [31:0]         count_ext;
  logic [31:0]         pay_hit;
  logic [KEY_BITS-1:0] rank_key;
  logic [63:0]         rank_key_ext;
  logic                rank_ok;

  skt_pkg::skt_ctrl_t  ctrl;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [31:0]         cell_pay [DEPTH];
  logic                cell_lt  [DEPTH];
  logic                cell_eq  [DEPTH];
  logic [DEPTH-1:0]    eq_vec;

  // Mask the request key to the stored key width
  assign in_key_ext = 64'(in_key);
  assign in_kw      = in_key_ext[KEY_BITS-1:0];
  assign cmp_key    = (state_r == ST_PURGE) ? bound_r : in_kw;

  // Effective capacity saturates at the row length
  assign eff_cap = (32'(cap_r) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_r);
  assign room    = 32'(count_r) < eff_cap;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic [31:0]         prev_pay;
    logic                prev_lt;
    logic [KEY_BITS-1:0] next_key;
    logic [31:0]         next_pay;

    if (i == 0) begin : g_head
      assign prev_key = in_kw;
      assign prev_pay = in_payload;
      assign prev_lt  = 1'b1;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = cell_key[i];
      assign next_pay = cell_pay[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    skt_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_valid (CW'(i) < count_r),
      .cmp_key    (cmp_key),
      .new_key    (in_kw),
      .new_pay    (in_payload),
      .prev_key   (prev_key),
      .prev_pay   (prev_pay),
      .prev_lt    (prev_lt),
      .next_key   (next_key),
      .next_pay   (next_pay),
      .key        (cell_key[i]),
      .pay        (cell_pay[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );

    assign eq_vec[i] = cell_eq[i];
  end

  assign found = |eq_vec;

  // Gather the matching payload and the entry at the requested rank
  always_comb begin
    pay_hit  = '0;
    rank_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_eq[i]) begin
        pay_hit = pay_hit | cell_pay[i];
      end
      if (32'(in_rank) == 32'(i)) begin
        rank_key = cell_key[i];
      end
    end
  end

  assign rank_ok      = 32'(in_rank) < 32'(count_r);
  assign rank_key_ext = 64'(rank_key);

  // Front entry falls inside the purge range
  assign purge_hit = (count_r != '0) &&
                     (cell_lt[0] || (purge_le_r && cell_eq[0]));

  // Row movement, count update and result selection
  always_comb begin
    ctrl        = '0;
    count_nxt   = count_r;
    state_nxt   = state_r;
    removed_nxt = removed_r;
    load_out    = 1'b0;
    res_ok      = 1'b0;
    res_pay     = '0;
    res_key     = '0;
    if (state_r == ST_PURGE) begin
      if (purge_hit) begin
        ctrl.shl    = 1'b1;
        count_nxt   = count_r - CW'(1);
        removed_nxt = 1'b1;
      end else if (out_free) begin
        load_out  = 1'b1;
        res_ok    = removed_r;
        state_nxt = ST_IDLE;
      end
    end else if (in_fire) begin
      load_out = 1'b1;
      case (in_operation)
        skt_pkg::OP_INSERT: begin
          if (room && !found) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CW'(1);
            res_ok    = 1'b1;
          end
        end
        skt_pkg::OP_ERASE: begin
          if (found) begin
            ctrl.del  = 1'b1;
            count_nxt = count_r - CW'(1);
            res_ok    = 1'b1;
          end
        end
        skt_pkg::OP_LOOKUP: begin
          res_ok  = found;
          res_pay = pay_hit;
        end
        skt_pkg::OP_PURGE_LE, skt_pkg::OP_PURGE_LT: begin
          load_out    = 1'b0;
          removed_nxt = 1'b0;
          state_nxt   = ST_PURGE;
        end
        skt_pkg::OP_RANK: begin
          res_ok  = rank_ok;
          res_key = rank_ok ? rank_key_ext[31:0] : '0;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  assign count_ext     = 32'(count_nxt);
  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= skt_pkg::CAP_W'(16);
      out_valid_r <= 1'b0;
      removed_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      removed_r   <= removed_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  // Latch the purge bound and the result item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bound_r    <= in_kw;
      purge_le_r <= (in_operation == skt_pkg::OP_PURGE_LE);
    end
    if (load_out) begin
      out_ok_r    <= res_ok;
      out_pay_r   <= res_pay;
      out_key_r   <= res_key;
      out_count_r <= count_ext[4:0];
      out_full_r  <= count_ext >= eff_cap;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_payload_out = out_pay_r;
  assign out_key_out     = out_key_r;
  assign out_count       = out_count_r;
  assign out_full_res    = out_full_r;

`ifndef NO_ASSERTIONS
  // Count never runs past the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above row length");

  // Keys are unique, so at most one cell matches
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(eq_vec) <= 1)
    else $error("more than one cell matches the key");

  // No item is taken while a purge is running
  a_purge_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PURGE) |-> !in_ready)
    else $error("item accepted during purge");

  // An accepted insert grows the count exactly when it reports success
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == skt_pkg::OP_INSERT) |=>
      (count_r == $past(count_r) + CW'(out_ok_r)))
    else $error("insert count mismatch");
`endif

endmodule

`default_nettype wire

// File: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry, compares it with the broadcast key and takes its next
// value from itself, a neighbour or the new item.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                clk,
  input  wire skt_pkg::skt_ctrl_t  ctrl,
  input  wire logic                cell_valid,
  input  wire logic [KEY_BITS-1:0] cmp_key,
  input  wire logic [KEY_BITS-1:0] new_key,
  input  wire logic [31:0]         new_pay,
  input  wire logic [KEY_BITS-1:0] prev_key,
  input  wire logic [31:0]         prev_pay,
  input  wire logic                prev_lt,
  input  wire logic [KEY_BITS-1:0] next_key,
  input  wire logic [31:0]         next_pay,
  output logic      [KEY_BITS-1:0] key,
  output logic      [31:0]         pay,
  output logic                     lt,
  output logic                     eq
);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;
  logic [31:0]         pay_r;
  logic [31:0]         pay_nxt;

  // Compare the held entry with the broadcast key; empty cells never match
  assign lt  = cell_valid && (key_r < cmp_key);
  assign eq  = cell_valid && (key_r == cmp_key);
  assign key = key_r;
  assign pay = pay_r;

  // Select the next entry from the row movement
  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.ins) begin
      if (prev_lt && !lt) begin
        key_nxt = new_key;
        pay_nxt = new_pay;
      end else if (!prev_lt) begin
        key_nxt = prev_key;
        pay_nxt = prev_pay;
      end
    end else if ((ctrl.del && !lt) || ctrl.shl) begin
      key_nxt = next_key;
      pay_nxt = next_pay;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

`default_nettype wire

// File: sim/sorted_key_table_with_range_purge_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Sends request items through the table with random gaps and result stalls.
// A scoreboard keeps its own sorted copy of the table and capacity, works out
// the result of every accepted item and checks each result item in order.
// ----------------------------------------------------------------------------

// Expected or observed result of one request
typedef struct {
  logic [2:0]  op;
  logic        ok;
  logic [31:0] payload;
  logic [31:0] key;
  logic [4:0]  count;
  logic        full;
} table_result_t;

// Sorted copy of the table and the queue of results still owed by the block
class sorted_table_tracker;
  localparam int unsigned ROWS = 16;

  logic [31:0]   row_key [ROWS];
  logic [31:0]   row_pay [ROWS];
  int unsigned   row_len;
  logic [4:0]    cap_reg;
  table_result_t due_results [$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   ok_seen;

  function new();
    row_len      = 0;
    cap_reg      = 5'd16;
    mismatches   = 0;
    results_seen = 0;
    ok_seen      = 0;
  endfunction

  function void set_capacity(input logic [4:0] value);
    cap_reg = value;
  endfunction

  // Capacity saturates at the number of rows
  function int unsigned usable_rows();
    return (cap_reg > ROWS) ? ROWS : int'(cap_reg);
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction

  // Apply one accepted request and queue the result it must produce
  function void note_request(input logic [2:0] op, input logic [31:0] key,
                             input logic [31:0] payload, input logic [3:0] rank);
    table_result_t r;
    int unsigned   pos;
    int unsigned   n;
    int unsigned   i;
    r.op      = op;
    r.ok      = 1'b0;
    r.payload = '0;
    r.key     = '0;
    // first row whose key is not below the request key
    pos = 0;
    while (pos < row_len && row_key[pos] < key) pos++;
    case (op)
      skt_pkg::OP_INSERT: begin
        // refuse when full or when the key is already held
        if (row_len < usable_rows() && !(pos < row_len && row_key[pos] == key)) begin
          for (i = row_len; i > pos; i--) begin
            row_key[i] = row_key[i - 1];
            row_pay[i] = row_pay[i - 1];
          end
          row_key[pos] = key;
          row_pay[pos] = payload;
          row_len++;
          r.ok = 1'b1;
        end
      end
      skt_pkg::OP_ERASE: begin
        if (pos < row_len && row_key[pos] == key) begin
          for (i = pos + 1; i < row_len; i++) begin
            row_key[i - 1] = row_key[i];
            row_pay[i - 1] = row_pay[i];
          end
          row_len--;
          r.ok = 1'b1;
        end
      end
      skt_pkg::OP_LOOKUP: begin
        if (pos < row_len && row_key[pos] == key) begin
          r.ok      = 1'b1;
          r.payload = row_pay[pos];
        end
      end
      skt_pkg::OP_PURGE_LE, skt_pkg::OP_PURGE_LT: begin
        // count the leading rows under the bound, then drop them
        n = 0;
        while (n < row_len && (op == skt_pkg::OP_PURGE_LE ? row_key[n] <= key
                                                           : row_key[n] < key))
          n++;
        if (n > 0) begin
          for (i = n; i < row_len; i++) begin
            row_key[i - n] = row_key[i];
            row_pay[i - n] = row_pay[i];
          end
          row_len -= n;
          r.ok = 1'b1;
        end
      end
      skt_pkg::OP_RANK: begin
        if (rank < row_len) begin
          r.ok  = 1'b1;
          r.key = row_key[rank];
        end
      end
      default: begin
        // unused codes leave the table alone
      end
    endcase
    r.count = row_len[4:0];
    r.full  = (row_len >= usable_rows());
    due_results.push_back(r);
  endfunction

  // Compare one result item with the oldest outstanding expectation
  function void check_result(input table_result_t got);
    table_result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      if (mismatches < 10)
        $display("ERROR: unexpected result item ok=%0d payload=%h key=%h count=%0d full=%0d",
                 got.ok, got.payload, got.key, got.count, got.full);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (want.ok) ok_seen++;
    if (got.ok !== want.ok || got.payload !== want.payload || got.key !== want.key ||
        got.count !== want.count || got.full !== want.full) begin
      if (mismatches < 10) begin
        $display("ERROR: op %0d expected ok=%0d payload=%h key=%h count=%0d full=%0d",
                 want.op, want.ok, want.payload, want.key, want.count, want.full);
        $display("       got ok=%0d payload=%h key=%h count=%0d full=%0d",
                 got.ok, got.payload, got.key, got.count, got.full);
      end
      mismatches++;
    end
  endfunction
endclass

module sorted_key_table_with_range_purge_core_tb;

  // Request codes the block treats as no-ops
  localparam logic [2:0]  OP_SPARE_6    = 3'd6;
  localparam logic [2:0]  OP_SPARE_7    = 3'd7;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 180;
  localparam int unsigned POOL_SIZE     = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_capacity  = '0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation  = skt_pkg::OP_INSERT;
  logic [31:0] in_key        = '0;
  logic [31:0] in_payload    = '0;
  logic [3:0]  in_rank       = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_ok;
  logic [31:0] out_payload_out;
  logic [31:0] out_key_out;
  logic [4:0]  out_count;
  logic        out_full_res;

  logic        tx_steady     = 1'b0;
  logic        rx_steady     = 1'b0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned sink_idle     = 0;
  int unsigned cycle_no      = 0;
  int unsigned requests_sent = 0;
  logic [31:0] key_pool [POOL_SIZE];

  sorted_table_tracker tracker = new();

  sorted_key_table_with_range_purge_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_payload_out (out_payload_out),
    .out_key_out     (out_key_out),
    .out_count       (out_count),
    .out_full_res    (out_full_res)
  );

  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_no, tracker.pending());
      $display("sorted_key_table_with_range_purge_core test failed");
      $finish;
    end
  end

  // Result side: check each item, then stall at random; one long hold-off
  always @(posedge clk) begin : result_sink
    table_result_t got;
    int unsigned   pause;
    if (rst_n && out_valid && out_ready) begin
      got.op      = '0;
      got.ok      = out_ok;
      got.payload = out_payload_out;
      got.key     = out_key_out;
      got.count   = out_count;
      got.full    = out_full_res;
      tracker.check_result(got);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      sink_idle <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (out_valid && out_ready) begin
      pause = rx_steady ? 0 : $urandom_range(0, 12);
      sink_idle <= pause;
      out_ready <= (pause == 0);
    end else if (sink_idle != 0) begin
      sink_idle <= sink_idle - 1;
      out_ready <= (sink_idle == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one request item after a random gap and hold it until accepted
  task automatic send_request(input logic [2:0] op, input logic [31:0] key,
                              input logic [31:0] payload, input logic [3:0] rank);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_payload   <= payload;
    in_rank      <= rank;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, key, payload, rank);
    requests_sent++;
  endtask

  // Drain the block, then write the capacity register
  task automatic write_capacity(input logic [4:0] value);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from the pool so that hits are common, some fully random
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic run_random_phase(input int unsigned n);
    int unsigned roll;
    logic [2:0]  op;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = skt_pkg::OP_INSERT;
      else if (roll < 57) op = skt_pkg::OP_ERASE;
      else if (roll < 71) op = skt_pkg::OP_LOOKUP;
      else if (roll < 74) op = skt_pkg::OP_PURGE_LE;
      else if (roll < 77) op = skt_pkg::OP_PURGE_LT;
      else if (roll < 96) op = skt_pkg::OP_RANK;
      else if (roll < 98) op = OP_SPARE_6;
      else                op = OP_SPARE_7;
      send_request(op, pick_key(), $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin : stimulus
    logic [4:0] phase_caps [PHASES];
    phase_caps    = '{5'd16, 5'd31, 5'd5, 5'd0, 5'd1, 5'd17, 5'd16, 5'd0, 5'd3, 5'd16};
    phase_caps[7] = 5'($urandom_range(0, 31));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, duplicates, misses, unused codes and both purge kinds
    send_request(skt_pkg::OP_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
    send_request(skt_pkg::OP_INSERT,   32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
    send_request(skt_pkg::OP_INSERT,   32'h0000_0000, 32'h1234_5678, 4'd0);
    send_request(skt_pkg::OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_LOOKUP,   32'd5,         32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_ERASE,    32'd5,         32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_RANK,     32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_RANK,     32'h0000_0000, 32'h0000_0000, 4'd1);
    send_request(skt_pkg::OP_RANK,     32'h0000_0000, 32'h0000_0000, 4'd15);
    send_request(OP_SPARE_6,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(OP_SPARE_7,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(skt_pkg::OP_INSERT,   32'd100,       32'hA5A5_A5A5, 4'd0);
    send_request(skt_pkg::OP_INSERT,   32'd50,        32'h5A5A_5A5A, 4'd0);
    send_request(skt_pkg::OP_PURGE_LT, 32'd50,        32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_PURGE_LE, 32'd50,        32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_PURGE_LE, 32'd10,        32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_PURGE_LT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_LOOKUP,   32'd100,       32'h0000_0000, 4'd0);
    send_request(skt_pkg::OP_RANK,     32'h0000_0000, 32'h0000_0000, 4'd0);
    // zero capacity refuses every insert
    write_capacity(5'd0);
    send_request(skt_pkg::OP_INSERT,   32'd7,         32'h0000_0007, 4'd0);
    // fill a capacity of two, then lower it below the count
    write_capacity(5'd2);
    send_request(skt_pkg::OP_INSERT,   32'd7,         32'h0000_0007, 4'd0);
    send_request(skt_pkg::OP_INSERT,   32'd3,         32'h0000_0003, 4'd0);
    send_request(skt_pkg::OP_INSERT,   32'd9,         32'h0000_0009, 4'd0);
    write_capacity(5'd1);
    send_request(skt_pkg::OP_RANK,     32'h0000_0000, 32'h0000_0000, 4'd1);

    // Random phases, one capacity setting each
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      tx_steady = (p % 3 == 1);
      rx_steady <= (p % 4 == 2);
      if (p == 1) hold_req <= 1'b1;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int unsigned j = 2; j < POOL_SIZE; j++)
        key_pool[j] = (j < 10) ? 32'($urandom_range(0, 63)) : $urandom;
      run_random_phase(PHASE_ITEMS);
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d request items over %0d capacity settings, with a %0d-cycle hold",
             requests_sent, PHASES + 3, LONG_HOLD);
    $display("%0d result items checked, %0d successful requests, %0d mismatches",
             tracker.results_seen, tracker.ok_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("sorted_key_table_with_range_purge_core test passed");
    end else begin
      $display("sorted_key_table_with_range_purge_core test failed");
    end
    $finish;
  end

endmodule
